// ===== rtl/cchm_pkg.sv =====
// ----------------------------------------------------------------------------
// cchm_pkg
// Types, sizes and command codes shared by the coalesced hash map modules.
// ----------------------------------------------------------------------------
package cchm_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int VAL_W  = 32;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_GET    = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // One table slot as held in the slot memory.
    typedef struct packed {
        logic [IDX_W-1:0]  next;
        logic              tail;
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_slot;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_CHECK,
        OP_SET_FROM,
        OP_PRED_STEP,
        OP_FP_INC,
        OP_WR_VALUE,
        OP_WR_NEW_HOME,
        OP_WR_HOME_LINK,
        OP_WR_NEW_FREE,
        OP_WR_PRED_LINK,
        OP_WR_MOVE,
        OP_WR_PREV_LINK,
        OP_CLR_AT,
        OP_RD_NEXT,
        OP_RM_MOVE,
        OP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [2:0] {
        RES_KEEP,
        RES_ZERO_OK,
        RES_STORED,
        RES_INPUT,
        RES_NOT_FOUND,
        RES_FULL
    } t_res_sel;

    typedef struct packed {
        t_dp_op   op;
        t_res_sel res;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  used_home;
        logic  hit;
        logic  tail;
        logic  found;
        logic  full;
        logic  own_home;
        logic  pred_match;
        logic  fp_used;
        logic  prev_v;
        logic  out_busy;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HOME,
        S_RD,
        S_CHK,
        S_DECIDE,
        S_PRD,
        S_PCHK,
        S_FREE_OWN,
        S_OWN_LINK,
        S_OWN_NEW,
        S_FREE_FOR,
        S_FOR_LINK,
        S_FOR_MOVE,
        S_FOR_NEW,
        S_RM,
        S_RM_MOVE,
        S_DONE
    } t_state;

endpackage

// ===== rtl/cchm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cchm_ctrl
// Request sequencer: walks chains, finds free slots and orders the writes.
// ----------------------------------------------------------------------------
module cchm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cchm_pkg::t_dp_stat i_stat,
    output cchm_pkg::t_dp_cmd  o_cmd
);
    import cchm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_HOME;
            end
            S_HOME: begin
                n_state = i_stat.used_home ? S_CHK : S_DECIDE;
            end
            S_RD:   n_state = S_CHK;
            S_CHK: begin
                if (i_stat.hit || i_stat.tail) n_state = S_DECIDE;
                else n_state = S_RD;
            end
            S_DECIDE: begin
                if (i_stat.mode == MODE_REMOVE) begin
                    n_state = i_stat.found ? S_RM : S_DONE;
                end else if (i_stat.mode == MODE_LOOKUP || i_stat.found || i_stat.full
                             || !i_stat.used_home) begin
                    n_state = S_DONE;
                end else if (i_stat.own_home) begin
                    n_state = S_FREE_OWN;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_PRD:  n_state = S_PCHK;
            S_PCHK: n_state = i_stat.pred_match ? S_FREE_FOR : S_PRD;
            S_FREE_OWN: begin
                if (!i_stat.fp_used) n_state = S_OWN_LINK;
            end
            S_OWN_LINK: n_state = S_OWN_NEW;
            S_OWN_NEW:  n_state = S_DONE;
            S_FREE_FOR: begin
                if (!i_stat.fp_used) n_state = S_FOR_LINK;
            end
            S_FOR_LINK: n_state = S_FOR_MOVE;
            S_FOR_MOVE: n_state = S_FOR_NEW;
            S_FOR_NEW:  n_state = S_DONE;
            S_RM: begin
                n_state = (i_stat.prev_v || i_stat.tail) ? S_DONE : S_RM_MOVE;
            end
            S_RM_MOVE: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op  = OP_NONE;
        o_cmd.res = RES_KEEP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_HOME: begin
                if (i_stat.used_home) o_cmd.op = OP_READ;
            end
            S_RD:   o_cmd.op = OP_READ;
            S_CHK: begin
                o_cmd.op = OP_CHECK;
            end
            S_DECIDE: begin
                case (i_stat.mode)
                    MODE_LOOKUP: o_cmd.res = i_stat.found ? RES_STORED : RES_NOT_FOUND;
                    MODE_REMOVE: o_cmd.res = i_stat.found ? RES_ZERO_OK : RES_NOT_FOUND;
                    MODE_PUT, MODE_GET: begin
                        if (i_stat.found) begin
                            if (i_stat.mode == MODE_PUT) begin
                                o_cmd.op  = OP_WR_VALUE;
                                o_cmd.res = RES_INPUT;
                            end else begin
                                o_cmd.res = RES_STORED;
                            end
                        end else if (i_stat.full) begin
                            o_cmd.res = RES_FULL;
                        end else begin
                            o_cmd.res = RES_INPUT;
                            if (!i_stat.used_home) o_cmd.op = OP_WR_NEW_HOME;
                            else if (!i_stat.own_home) o_cmd.op = OP_SET_FROM;
                        end
                    end
                    default: o_cmd.res = RES_KEEP;
                endcase
            end
            S_PRD:  o_cmd.op = OP_READ;
            S_PCHK: begin
                if (!i_stat.pred_match) o_cmd.op = OP_PRED_STEP;
            end
            S_FREE_OWN, S_FREE_FOR: begin
                if (i_stat.fp_used) o_cmd.op = OP_FP_INC;
            end
            S_OWN_LINK: o_cmd.op = OP_WR_HOME_LINK;
            S_OWN_NEW:  o_cmd.op = OP_WR_NEW_FREE;
            S_FOR_LINK: o_cmd.op = OP_WR_PRED_LINK;
            S_FOR_MOVE: o_cmd.op = OP_WR_MOVE;
            S_FOR_NEW:  o_cmd.op = OP_WR_NEW_HOME;
            S_RM: begin
                if (i_stat.prev_v) o_cmd.op = OP_WR_PREV_LINK;
                else if (i_stat.tail) o_cmd.op = OP_CLR_AT;
                else o_cmd.op = OP_RD_NEXT;
            end
            S_RM_MOVE: o_cmd.op = OP_RM_MOVE;
            S_DONE: begin
                if (!i_stat.out_busy) o_cmd.op = OP_OUT_LOAD;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/cchm_dp.sv =====
// ----------------------------------------------------------------------------
// cchm_dp
// Slot memory, occupancy bits, walk registers, free pointer and result word.
// ----------------------------------------------------------------------------
module cchm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cchm_pkg::t_dp_cmd             i_cmd,
    input  logic [1:0]                    i_mode,
    input  logic [cchm_pkg::KEY_W-1:0]    i_key,
    input  logic [cchm_pkg::HASH_W-1:0]   i_key_hash,
    input  logic [cchm_pkg::VAL_W-1:0]    i_value,
    input  logic                          i_out_stall,
    output cchm_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [cchm_pkg::VAL_W-1:0]    o_result_value,
    output logic [1:0]                    o_status
);
    import cchm_pkg::*;

    t_slot r_mem [SLOTS];

    t_mode             r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [HASH_W-1:0] r_hash;
    logic [VAL_W-1:0]  r_val;
    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_prev;
    logic              r_prev_v;
    t_slot             r_prev_word;
    t_slot             r_home_word;
    logic              r_first;
    logic              r_found;
    t_slot             r_rdata;
    logic [SLOTS-1:0]  r_used;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_fp;
    logic [IDX_W-1:0]  r_mv;
    logic [VAL_W-1:0]  r_res;
    t_status           r_stat;
    logic              r_ovalid;
    logic              r_ofound;
    logic [VAL_W-1:0]  r_ores;
    t_status           r_ostat;

    logic [IDX_W-1:0] home;
    logic             hit;
    logic             we;
    logic [IDX_W-1:0] wa;
    t_slot            wd;
    logic             re;
    logic [IDX_W-1:0] ra;

    assign home = r_hash[IDX_W-1:0];
    assign hit  = r_used[r_cur] && (r_rdata.hash == r_hash) && (r_rdata.key == r_key);

    always_comb begin
        we = 1'b0;
        wa = r_cur;
        wd = r_rdata;
        re = 1'b0;
        ra = r_cur;
        case (i_cmd.op)
            OP_READ: re = 1'b1;
            OP_RD_NEXT: begin
                re = 1'b1;
                ra = r_rdata.next;
            end
            OP_WR_VALUE: begin
                we       = 1'b1;
                wd.value = r_val;
            end
            OP_WR_NEW_HOME: begin
                we       = 1'b1;
                wa       = home;
                wd.next  = '0;
                wd.tail  = 1'b1;
                wd.hash  = r_hash;
                wd.key   = r_key;
                wd.value = r_val;
            end
            OP_WR_HOME_LINK: begin
                we      = 1'b1;
                wa      = home;
                wd      = r_home_word;
                wd.next = r_fp;
                wd.tail = 1'b0;
            end
            OP_WR_NEW_FREE: begin
                we       = 1'b1;
                wa       = r_fp;
                wd.next  = r_home_word.next;
                wd.tail  = r_home_word.tail;
                wd.hash  = r_hash;
                wd.key   = r_key;
                wd.value = r_val;
            end
            OP_WR_PRED_LINK: begin
                we      = 1'b1;
                wd.next = r_fp;
            end
            OP_WR_MOVE: begin
                we = 1'b1;
                wa = r_fp;
                wd = r_home_word;
            end
            OP_WR_PREV_LINK: begin
                we      = 1'b1;
                wa      = r_prev;
                wd      = r_prev_word;
                wd.next = r_rdata.next;
                wd.tail = r_rdata.tail;
            end
            OP_RM_MOVE: we = 1'b1;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (re) r_rdata <= r_mem[ra];
    end

    // Request and walk registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode   <= t_mode'(i_mode);
                r_key    <= i_key;
                r_hash   <= i_key_hash;
                r_val    <= i_value;
                r_cur    <= i_key_hash[IDX_W-1:0];
                r_prev_v <= 1'b0;
                r_first  <= 1'b1;
                r_found  <= 1'b0;
            end
            OP_CHECK: begin
                if (r_first) r_home_word <= r_rdata;
                r_first <= 1'b0;
                if (hit) begin
                    r_found <= 1'b1;
                end else if (!r_rdata.tail) begin
                    r_prev      <= r_cur;
                    r_prev_word <= r_rdata;
                    r_prev_v    <= 1'b1;
                    r_cur       <= r_rdata.next;
                end
            end
            OP_SET_FROM:  r_cur <= r_home_word.hash[IDX_W-1:0];
            OP_PRED_STEP: r_cur <= r_rdata.next;
            OP_RD_NEXT:   r_mv  <= r_rdata.next;
            default: r_first <= r_first;
        endcase
        case (i_cmd.res)
            RES_ZERO_OK: begin
                r_res  <= '0;
                r_stat <= ST_OK;
            end
            RES_STORED: begin
                r_res  <= r_rdata.value;
                r_stat <= ST_OK;
            end
            RES_INPUT: begin
                r_res  <= r_val;
                r_stat <= ST_OK;
            end
            RES_NOT_FOUND: begin
                r_res  <= '0;
                r_stat <= ST_NOT_FOUND;
            end
            RES_FULL: begin
                r_res  <= '0;
                r_stat <= ST_FULL;
            end
            default: r_res <= r_res;
        endcase
    end

    // Occupancy, entry count and free scan pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
            r_fp    <= '0;
        end else begin
            case (i_cmd.op)
                OP_FP_INC: r_fp <= r_fp + 1'b1;
                OP_WR_NEW_HOME: begin
                    r_used[home] <= 1'b1;
                    r_count      <= r_count + 1'b1;
                end
                OP_WR_NEW_FREE: begin
                    r_used[r_fp] <= 1'b1;
                    r_count      <= r_count + 1'b1;
                end
                OP_WR_MOVE: r_used[r_fp] <= 1'b1;
                OP_WR_PREV_LINK, OP_CLR_AT: begin
                    r_used[r_cur] <= 1'b0;
                    r_count       <= r_count - 1'b1;
                end
                OP_RM_MOVE: begin
                    r_used[r_mv] <= 1'b0;
                    r_count      <= r_count - 1'b1;
                end
                default: r_fp <= r_fp;
            endcase
        end
    end

    // Output register: holds one finished word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT_LOAD) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT_LOAD) begin
            r_ofound <= r_found;
            r_ores   <= r_res;
            r_ostat  <= r_stat;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_found        = r_ofound;
    assign o_result_value = r_ores;
    assign o_status       = r_ostat;

    assign o_stat.mode       = r_mode;
    assign o_stat.used_home  = r_used[home];
    assign o_stat.hit        = hit;
    assign o_stat.tail       = r_rdata.tail;
    assign o_stat.found      = r_found;
    assign o_stat.full       = (r_count >= CNT_W'(SLOTS));
    assign o_stat.own_home   = (r_home_word.hash[IDX_W-1:0] == home);
    assign o_stat.pred_match = !r_rdata.tail && (r_rdata.next == home);
    assign o_stat.fp_used    = r_used[r_fp];
    assign o_stat.prev_v     = r_prev_v;
    assign o_stat.out_busy   = r_ovalid && i_out_stall;

endmodule

// ===== rtl/coalesced_hash_map.sv =====
// ----------------------------------------------------------------------------
// coalesced_hash_map
// Fixed 64-slot hash table with coalesced chains and relocation.
// ----------------------------------------------------------------------------
// The block takes one request word at a time (put, lookup, get-or-insert or
// remove) and returns exactly one result word per request. Every request
// passes through acceptance, the home-slot check, the decision and the
// handoff to the output register. The home slot's read overlaps its check,
// and its compare follows as a step of its own. Each further chain entry
// visited is read and then compared through the slot memory's one read port.
// An insert that meets a foreign entry in its home slot first walks that
// entry's chain to its predecessor, again reading and comparing each entry.
// Finding a free slot steps the free pointer over each occupied slot. Two
// writes follow for a same-chain insert and three for a relocation. A remove
// of a present key relinks its predecessor past it, clears a lone home
// entry, or moves the next entry into its slot. The memory port and the
// linear free-slot scan set how long a request takes. The input stalls while
// a request is in progress; the finished result sits in an output register,
// so a new request is accepted while the previous result waits to be taken.
// Occupancy bits and the entry count clear at reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module coalesced_hash_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_mode,
    input  logic [cchm_pkg::KEY_W-1:0]  i_key,
    input  logic [cchm_pkg::HASH_W-1:0] i_key_hash,
    input  logic [cchm_pkg::VAL_W-1:0]  i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [cchm_pkg::VAL_W-1:0]  o_result_value,
    output logic [1:0]                  o_status
);
    import cchm_pkg::*;

    // Commands flow from the sequencer to the datapath, status flows back.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    cchm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cchm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_key          (i_key),
        .i_key_hash     (i_key_hash),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule
